[src/min_request_power_limit_arbiter_defines.svh]
// ============================================================================
// min_request_power_limit_arbiter_defines
// Assertion macros used by the arbiter RTL; empty under synthesis.
// ============================================================================
`ifndef MIN_REQUEST_POWER_LIMIT_ARBITER_DEFINES_SVH
`define MIN_REQUEST_POWER_LIMIT_ARBITER_DEFINES_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/mrpla_pkg.sv]
// ============================================================================
// mrpla_pkg
// Beat types, request codes and scan control types of the power limit arbiter.
// ============================================================================
package mrpla_pkg;

    localparam int KIND_W      = 2;
    localparam int VALUE_KINDS = 3;

    localparam logic [2:0] REQ_COMMIT  = 3'd0;
    localparam logic [2:0] REQ_PREVIEW = 3'd1;
    localparam logic [2:0] REQ_REMOVE  = 3'd2;
    localparam logic [2:0] REQ_DROP    = 3'd3;
    localparam logic [2:0] REQ_QUERY   = 3'd4;

    localparam logic [KIND_W-1:0] KIND_POWER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FLOOR = 2'd3;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [KIND_W-1:0] request_kind;
        logic [3:0]        requester;
        logic [1:0]        control_type;
        logic [31:0]       request_value;
    } t_req_beat;

    typedef struct packed {
        logic [31:0] result_value;
        logic        result_valid;
    } t_rsp_beat;

    typedef struct packed {
        logic clr;
        logic en;
        logic pres;
        logic rq_pres;
        logic fl_pres;
        logic fl_bit;
    } t_acc_ctl;

    typedef struct packed {
        logic found;
        logic any;
        logic fl_found;
        logic fl_or;
    } t_acc_sts;

endpackage

[src/mrpla_ram.sv]
// ============================================================================
// mrpla_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module mrpla_ram #(
    parameter int DEPTH = 192,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/mrpla_min_acc.sv]
// ============================================================================
// mrpla_min_acc
// Scan accumulator: running minimum of present requests, floor OR and
// requester occupancy over one pass through the request store.
// ============================================================================
module mrpla_min_acc #(
    parameter int VALUE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mrpla_pkg::t_acc_ctl i_ctl,
    input  logic [VALUE_BITS-1:0] i_value,
    output mrpla_pkg::t_acc_sts o_sts,
    output logic [VALUE_BITS-1:0] o_min
);

    mrpla_pkg::t_acc_sts   r_sts;
    logic [VALUE_BITS-1:0] r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sts <= '0;
        end else if (i_ctl.clr) begin
            r_sts <= '0;
        end else if (i_ctl.en) begin
            if (i_ctl.pres && (!r_sts.found || i_value < r_min)) begin
                r_sts.found <= 1'b1;
            end
            if (i_ctl.fl_pres) begin
                r_sts.fl_found <= 1'b1;
                r_sts.fl_or    <= r_sts.fl_or | i_ctl.fl_bit;
            end
            r_sts.any <= r_sts.any | i_ctl.rq_pres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_min <= '0;
        end else if (i_ctl.en && i_ctl.pres && (!r_sts.found || i_value < r_min)) begin
            r_min <= i_value;
        end
    end

    assign o_sts = r_sts;
    assign o_min = r_min;

endmodule

[src/min_request_power_limit_arbiter.sv]
// ============================================================================
// min_request_power_limit_arbiter
// Minimum-request arbiter for power limits, time windows, duty cycles and a
// per-requester floor bit.
//
// Request channel: i_req_valid / o_req_stall carry one request beat (commit,
// preview, remove requester, drop one power request, query). Response
// channel: o_rsp_valid / i_rsp_stall return exactly one beat per request.
// Requests are served one at a time. A commit or preview scans every
// requester's entry, one per cycle: the request RAM for value kinds, the
// floor bits for the floor kind. It answers through S_END and S_DONE. A
// query or drop answers through S_QUERY_RD and S_QUERY. A remove rescans,
// per kind the requester held, the control types it held and the last one,
// plus the floor bits if it held one.
// Reset clears all presence bits; the value RAMs need no clearing pass,
// since a stored value is used only while its presence bit is set.
// A stalled response is held in the output register; the next request is
// taken meanwhile and completes, then waits until that register frees.
// ============================================================================
`include "min_request_power_limit_arbiter_defines.svh"

module min_request_power_limit_arbiter #(
    parameter int REQUESTERS    = 16,
    parameter int CONTROL_TYPES = 4,
    parameter int VALUE_BITS    = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_stall,
    input  mrpla_pkg::t_req_beat i_req,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_stall,
    output mrpla_pkg::t_rsp_beat o_rsp
);

    localparam int RW     = $clog2(REQUESTERS);
    localparam int CW     = (CONTROL_TYPES > 1) ? $clog2(CONTROL_TYPES) : 1;
    localparam int KW     = mrpla_pkg::KIND_W;
    localparam int NKIND  = mrpla_pkg::VALUE_KINDS;
    localparam int SDEPTH = NKIND << (RW + CW);
    localparam int ADEPTH = NKIND << CW;
    localparam int PDEPTH = NKIND << RW;
    localparam int NREQ   = 1 << RW;
    localparam int NTYPE  = 1 << CW;
    localparam logic [RW:0]   R_CNT  = (RW + 1)'(REQUESTERS);
    localparam logic [CW-1:0] T_LAST = CW'(CONTROL_TYPES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_END,
        S_RMV,
        S_QUERY_RD,
        S_QUERY,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MODE_COMMIT,
        MODE_PREVIEW,
        MODE_REMOVE
    } t_mode;

    t_state                r_state;
    t_mode                 r_mode;
    logic [KW-1:0]         r_kind;
    logic                  r_t_lt;
    logic [CW-1:0]         r_ti;
    logic [RW-1:0]         r_req;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_fbit;
    logic                  r_ovr;
    logic [KW-1:0]         r_s_kind;
    logic [CW-1:0]         r_s_type;
    logic [RW:0]           r_iss;

    logic r_b_vld;
    logic r_b_ovr;
    logic r_b_pres;
    logic r_b_rq;
    logic r_b_fp;
    logic r_b_fb;

    logic [SDEPTH-1:0] r_req_pres;
    logic [PDEPTH-1:0] r_rq_pres;
    logic [NREQ-1:0]   r_floor_pres;
    logic [NREQ-1:0]   r_floor_req;
    logic [ADEPTH-1:0] r_arb_pres;
    logic              r_floor_val;
    logic              r_floor_vld;
    logic [ADEPTH-1:0] r_had;
    logic [NKIND-1:0]  r_rp;
    logic              r_fp;

    mrpla_pkg::t_rsp_beat r_res;
    mrpla_pkg::t_rsp_beat r_out;
    logic                 r_out_valid;

    logic                  in_r_ok;
    logic                  in_t_lt;
    logic                  in_t_ok;
    logic [CW-1:0]         in_ti;
    logic [RW-1:0]         in_req;
    logic [RW-1:0]         scan_q;
    logic                  scan_issue;
    logic                  scan_hit;
    logic                  scan_val_kind;
    logic [KW+RW+CW-1:0]   s_addr;
    logic [KW+RW-1:0]      p_addr;
    logic [VALUE_BITS-1:0] s_rd;
    logic [VALUE_BITS-1:0] a_rd;
    logic                  s_wr_en;
    logic                  a_wr_en;
    logic                  a_rd_en;

    mrpla_pkg::t_acc_ctl   acc_ctl;
    mrpla_pkg::t_acc_sts   acc_sts;
    logic [VALUE_BITS-1:0] acc_min;
    logic [VALUE_BITS-1:0] acc_value;

    assign in_r_ok = 32'(i_req.requester) < REQUESTERS;
    assign in_t_lt = 32'(i_req.control_type) < CONTROL_TYPES;
    assign in_t_ok = (i_req.request_kind == mrpla_pkg::KIND_FLOOR) || in_t_lt;
    assign in_ti   = in_t_lt ? CW'(i_req.control_type) : '0;
    assign in_req  = RW'(i_req.requester);

    assign scan_q        = r_iss[RW-1:0];
    assign scan_issue    = (r_state == S_SCAN) && (r_iss < R_CNT);
    assign scan_hit      = r_ovr && (scan_q == r_req);
    assign scan_val_kind = (r_s_kind != mrpla_pkg::KIND_FLOOR);
    assign s_addr        = {r_s_kind, scan_q, r_s_type};
    assign p_addr        = {r_s_kind, scan_q};

    assign s_wr_en = (r_state == S_END) && (r_mode == MODE_COMMIT) && scan_val_kind;
    assign a_wr_en = (r_state == S_END) && scan_val_kind
                     && ((r_mode == MODE_COMMIT)
                         || ((r_mode == MODE_REMOVE) && r_had[{r_s_kind, r_s_type}]
                             && acc_sts.found));
    assign a_rd_en = (r_state == S_QUERY_RD) && (r_kind != mrpla_pkg::KIND_FLOOR) && r_t_lt;

    mrpla_ram #(
        .DEPTH (SDEPTH),
        .WIDTH (VALUE_BITS)
    ) u_req_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr_en),
        .i_wr_addr ({r_s_kind, r_req, r_s_type}),
        .i_wr_data (r_val),
        .i_rd_en   (scan_issue && scan_val_kind),
        .i_rd_addr (s_addr),
        .o_rd_data (s_rd)
    );

    mrpla_ram #(
        .DEPTH (ADEPTH),
        .WIDTH (VALUE_BITS)
    ) u_arb_ram (
        .i_clk     (i_clk),
        .i_wr_en   (a_wr_en),
        .i_wr_addr ({r_s_kind, r_s_type}),
        .i_wr_data (acc_min),
        .i_rd_en   (a_rd_en),
        .i_rd_addr ({r_kind, r_ti}),
        .o_rd_data (a_rd)
    );

    assign acc_ctl.clr     = (r_state == S_IDLE) || (r_state == S_RMV);
    assign acc_ctl.en      = r_b_vld;
    assign acc_ctl.pres    = r_b_pres;
    assign acc_ctl.rq_pres = r_b_rq;
    assign acc_ctl.fl_pres = r_b_fp;
    assign acc_ctl.fl_bit  = r_b_fb;
    assign acc_value       = r_b_ovr ? r_val : s_rd;

    mrpla_min_acc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_min_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_value (acc_value),
        .o_sts   (acc_sts),
        .o_min   (acc_min)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_b_vld      <= 1'b0;
            r_req_pres   <= '0;
            r_rq_pres    <= '0;
            r_floor_pres <= '0;
            r_floor_req  <= '0;
            r_arb_pres   <= '0;
            r_floor_val  <= 1'b0;
            r_floor_vld  <= 1'b0;
        end else begin
            r_b_vld  <= scan_issue;
            r_b_ovr  <= scan_hit;
            r_b_pres <= scan_val_kind && (scan_hit || r_req_pres[s_addr]);
            r_b_rq   <= scan_val_kind && r_rq_pres[p_addr];
            r_b_fp   <= !scan_val_kind && (scan_hit || r_floor_pres[scan_q]);
            r_b_fb   <= scan_hit ? r_fbit : r_floor_req[scan_q];
            r_iss    <= scan_issue ? r_iss + (RW + 1)'(1) : '0;

            if ((r_state == S_DONE) && (!r_out_valid || !i_rsp_stall)) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_kind   <= i_req.request_kind;
                        r_t_lt   <= in_t_lt;
                        r_ti     <= in_ti;
                        r_req    <= in_req;
                        r_val    <= VALUE_BITS'(i_req.request_value);
                        r_fbit   <= i_req.request_value[0];
                        r_s_kind <= i_req.request_kind;
                        r_s_type <= in_ti;
                        r_ovr    <= 1'b1;
                        r_state  <= S_QUERY_RD;
                        case (i_req.req_type)
                            mrpla_pkg::REQ_COMMIT: begin
                                if (in_r_ok && in_t_ok) begin
                                    r_mode  <= MODE_COMMIT;
                                    r_state <= S_SCAN;
                                end
                            end
                            mrpla_pkg::REQ_PREVIEW: begin
                                r_mode <= MODE_PREVIEW;
                                if (in_r_ok && in_t_ok) begin
                                    r_state <= S_SCAN;
                                end else begin
                                    r_res   <= '0;
                                    r_state <= S_DONE;
                                end
                            end
                            mrpla_pkg::REQ_REMOVE: begin
                                if (in_r_ok) begin
                                    r_mode               <= MODE_REMOVE;
                                    r_ovr                <= 1'b0;
                                    r_s_kind             <= mrpla_pkg::KIND_POWER;
                                    r_s_type             <= '0;
                                    r_fp                 <= r_floor_pres[in_req];
                                    r_floor_pres[in_req] <= 1'b0;
                                    r_floor_req[in_req]  <= 1'b0;
                                    for (int k = 0; k < NKIND; k++) begin
                                        r_rp[k] <= r_rq_pres[{KW'(k), in_req}];
                                        r_rq_pres[{KW'(k), in_req}] <= 1'b0;
                                        for (int t = 0; t < NTYPE; t++) begin
                                            r_had[{KW'(k), CW'(t)}] <=
                                                r_req_pres[{KW'(k), in_req, CW'(t)}];
                                            r_req_pres[{KW'(k), in_req, CW'(t)}] <= 1'b0;
                                        end
                                    end
                                    r_state <= S_RMV;
                                end
                            end
                            mrpla_pkg::REQ_DROP: begin
                                if (in_r_ok && in_t_lt) begin
                                    r_req_pres[{mrpla_pkg::KIND_POWER, in_req, in_ti}] <= 1'b0;
                                end
                            end
                            mrpla_pkg::REQ_QUERY: begin
                                r_state <= S_QUERY_RD;
                            end
                            default: begin
                                r_state <= S_QUERY_RD;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!scan_issue) begin
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    r_state <= S_DONE;
                    case (r_mode)
                        MODE_COMMIT: begin
                            if (!scan_val_kind) begin
                                r_floor_req[r_req]  <= r_fbit;
                                r_floor_pres[r_req] <= 1'b1;
                                r_floor_val         <= acc_sts.fl_or;
                                r_floor_vld         <= 1'b1;
                                r_res <= '{result_value: 32'(acc_sts.fl_or), result_valid: 1'b1};
                            end else begin
                                r_req_pres[{r_s_kind, r_req, r_s_type}] <= 1'b1;
                                r_rq_pres[{r_s_kind, r_req}]            <= 1'b1;
                                r_arb_pres[{r_s_kind, r_s_type}]        <= 1'b1;
                                r_res <= '{result_value: 32'(acc_min), result_valid: 1'b1};
                            end
                        end
                        MODE_PREVIEW: begin
                            if (!scan_val_kind) begin
                                r_res <= '{result_value: 32'(acc_sts.fl_or), result_valid: 1'b1};
                            end else begin
                                r_res <= '{result_value: 32'(acc_min), result_valid: 1'b1};
                            end
                        end
                        MODE_REMOVE: begin
                            if (!scan_val_kind) begin
                                r_floor_val <= acc_sts.fl_found && acc_sts.fl_or;
                                r_floor_vld <= acc_sts.fl_found;
                                r_state     <= S_QUERY_RD;
                            end else begin
                                if (r_had[{r_s_kind, r_s_type}] && acc_sts.found) begin
                                    r_arb_pres[{r_s_kind, r_s_type}] <= 1'b1;
                                end
                                if (r_s_type == T_LAST) begin
                                    if (!acc_sts.any) begin
                                        for (int t = 0; t < NTYPE; t++) begin
                                            r_arb_pres[{r_s_kind, CW'(t)}] <= 1'b0;
                                        end
                                    end
                                    r_s_kind <= r_s_kind + KW'(1);
                                    r_s_type <= '0;
                                end else begin
                                    r_s_type <= r_s_type + CW'(1);
                                end
                                r_state <= S_RMV;
                            end
                        end
                        default: begin
                            r_state <= S_QUERY_RD;
                        end
                    endcase
                end
                S_RMV: begin
                    if (!scan_val_kind) begin
                        r_state <= r_fp ? S_SCAN : S_QUERY_RD;
                    end else if (!r_rp[r_s_kind]) begin
                        r_s_kind <= r_s_kind + KW'(1);
                        r_s_type <= '0;
                    end else if (r_had[{r_s_kind, r_s_type}] || (r_s_type == T_LAST)) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_s_type <= r_s_type + CW'(1);
                    end
                end
                S_QUERY_RD: begin
                    r_state <= S_QUERY;
                end
                S_QUERY: begin
                    if (r_kind == mrpla_pkg::KIND_FLOOR) begin
                        if (r_floor_vld) begin
                            r_res <= '{result_value: 32'(r_floor_val), result_valid: 1'b1};
                        end else begin
                            r_res <= '0;
                        end
                    end else if (r_t_lt && r_arb_pres[{r_kind, r_ti}]) begin
                        r_res <= '{result_value: 32'(a_rd), result_valid: 1'b1};
                    end else begin
                        r_res <= '0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_rsp_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_req_valid && !o_req_stall, o_req_stall)
    `ASSERT_IMPLY(a_rsp_from_done, i_clk, i_rst_n, $rose(o_rsp_valid), $past(r_state == S_DONE))
    `ASSERT_NEXT(a_scan_holds_pres, i_clk, i_rst_n, r_state == S_SCAN, $stable(r_req_pres) && $stable(r_arb_pres))
    `ASSERT_IMPLY(a_floor_val_valid, i_clk, i_rst_n, r_floor_val, r_floor_vld)

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the minimum-request power limit arbiter.
//
// Request beats go in through a valid/stall channel with random gaps. A
// behavioral copy of the arbiter tracks every request, presence bit and
// arbitrated value, and queues the response each accepted beat must produce.
// Responses are drained under random stall and compared field by field in
// order. Directed cases cover empty queries, commit, preview, floor bits,
// drop and remove, and the spare request codes. A long random run then
// follows, aimed at small requester pools so that kinds fill and empty.
// ============================================================================
module tb;

    localparam int REQUESTERS     = 16;
    localparam int CTRL_TYPES     = 4;
    localparam int RANDOM_ITEMS   = 1430;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int NKIND          = mrpla_pkg::VALUE_KINDS;

    localparam logic [mrpla_pkg::KIND_W-1:0] KIND_WINDOW = 2'd1;
    localparam logic [mrpla_pkg::KIND_W-1:0] KIND_DUTY   = 2'd2;

    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_req_valid;
    logic                 o_req_stall;
    mrpla_pkg::t_req_beat i_req;
    logic                 o_rsp_valid;
    logic                 i_rsp_stall;
    mrpla_pkg::t_rsp_beat o_rsp;

    logic [31:0] req_val  [NKIND][REQUESTERS][CTRL_TYPES];
    bit          req_pres [NKIND][REQUESTERS][CTRL_TYPES];
    bit          rq_pres  [NKIND][REQUESTERS];
    bit          flr_bit  [REQUESTERS];
    bit          flr_pres [REQUESTERS];
    logic [31:0] arb_val  [NKIND][CTRL_TYPES];
    bit          arb_pres [NKIND][CTRL_TYPES];
    bit          flr_arb_v;
    bit          flr_arb_ok;

    mrpla_pkg::t_rsp_beat arb_result_q[$];
    mrpla_pkg::t_rsp_beat head_result;
    int                   err_count;
    int                   idle_cycles;
    bit                   quiet;

    min_request_power_limit_arbiter #(
        .REQUESTERS   (REQUESTERS),
        .CONTROL_TYPES(CTRL_TYPES),
        .VALUE_BITS   (32)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_stall(o_req_stall),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_stall(i_rsp_stall),
        .o_rsp      (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [31:0] lowest_request(input int k, input int t, output bit found);
        logic [31:0] best;
        best  = '0;
        found = 1'b0;
        for (int r = 0; r < REQUESTERS; r++) begin
            if (req_pres[k][r][t] && (!found || req_val[k][r][t] < best)) begin
                best  = req_val[k][r][t];
                found = 1'b1;
            end
        end
        return best;
    endfunction

    function automatic bit floor_or(output bit found);
        bit v;
        v     = 1'b0;
        found = 1'b0;
        for (int r = 0; r < REQUESTERS; r++) begin
            if (flr_pres[r]) begin
                found = 1'b1;
                v     = v | flr_bit[r];
            end
        end
        return v;
    endfunction

    function automatic void retire_requester(input int r);
        bit          had [CTRL_TYPES];
        bit          any;
        bit          found;
        bit          fv;
        logic [31:0] v;
        for (int k = 0; k < NKIND; k++) begin
            if (!rq_pres[k][r]) continue;
            for (int t = 0; t < CTRL_TYPES; t++) begin
                had[t]         = req_pres[k][r][t];
                req_pres[k][r][t] = 1'b0;
            end
            rq_pres[k][r] = 1'b0;
            any = 1'b0;
            for (int q = 0; q < REQUESTERS; q++) any = any | rq_pres[k][q];
            for (int t = 0; t < CTRL_TYPES; t++) begin
                if (!any) begin
                    arb_pres[k][t] = 1'b0;
                end else if (had[t]) begin
                    v = lowest_request(k, t, found);
                    if (found) begin
                        arb_val[k][t]  = v;
                        arb_pres[k][t] = 1'b1;
                    end
                end
            end
        end
        if (flr_pres[r]) begin
            flr_pres[r] = 1'b0;
            flr_bit[r]  = 1'b0;
            fv = floor_or(found);
            flr_arb_v  = found & fv;
            flr_arb_ok = found;
        end
    endfunction

    function automatic mrpla_pkg::t_rsp_beat arbitrate(input mrpla_pkg::t_req_beat b);
        mrpla_pkg::t_rsp_beat res;
        int                   k;
        int                   r;
        int                   t;
        logic [31:0]          saved_v;
        bit                   saved_p;
        bit                   found;
        bit                   fv;
        k   = b.request_kind;
        r   = b.requester;
        t   = b.control_type;
        res = '0;
        case (b.req_type)
            mrpla_pkg::REQ_COMMIT: begin
                if (b.request_kind == mrpla_pkg::KIND_FLOOR) begin
                    flr_bit[r]  = b.request_value[0];
                    flr_pres[r] = 1'b1;
                    flr_arb_v   = floor_or(found);
                    flr_arb_ok  = 1'b1;
                end else begin
                    req_val[k][r][t]  = b.request_value;
                    req_pres[k][r][t] = 1'b1;
                    rq_pres[k][r]     = 1'b1;
                    arb_val[k][t]     = lowest_request(k, t, found);
                    arb_pres[k][t]    = 1'b1;
                end
            end
            mrpla_pkg::REQ_PREVIEW: begin
                if (b.request_kind == mrpla_pkg::KIND_FLOOR) begin
                    saved_v     = {31'b0, flr_bit[r]};
                    saved_p     = flr_pres[r];
                    flr_bit[r]  = b.request_value[0];
                    flr_pres[r] = 1'b1;
                    fv          = floor_or(found);
                    flr_bit[r]  = saved_v[0];
                    flr_pres[r] = saved_p;
                    res.result_value = {31'b0, fv};
                end else begin
                    saved_v           = req_val[k][r][t];
                    saved_p           = req_pres[k][r][t];
                    req_val[k][r][t]  = b.request_value;
                    req_pres[k][r][t] = 1'b1;
                    res.result_value  = lowest_request(k, t, found);
                    req_val[k][r][t]  = saved_v;
                    req_pres[k][r][t] = saved_p;
                end
                res.result_valid = 1'b1;
                return res;
            end
            mrpla_pkg::REQ_REMOVE: retire_requester(r);
            mrpla_pkg::REQ_DROP:   req_pres[mrpla_pkg::KIND_POWER][r][t] = 1'b0;
            default: ;
        endcase
        if (b.request_kind == mrpla_pkg::KIND_FLOOR) begin
            if (flr_arb_ok) begin
                res.result_value = {31'b0, flr_arb_v};
                res.result_valid = 1'b1;
            end
        end else if (arb_pres[k][t]) begin
            res.result_value = arb_val[k][t];
            res.result_valid = 1'b1;
        end
        return res;
    endfunction

    task automatic send_beat(input logic [2:0] op, input logic [mrpla_pkg::KIND_W-1:0] kind,
                             input logic [3:0] who, input logic [1:0] ct,
                             input logic [31:0] value);
        mrpla_pkg::t_req_beat beat;
        int                   gap;
        beat.req_type      = op;
        beat.request_kind  = kind;
        beat.requester     = who;
        beat.control_type  = ct;
        beat.request_value = value;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            i_req_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_valid = 1'b1;
        i_req       = beat;
        do @(posedge i_clk); while (o_req_stall);
        arb_result_q.insert(arb_result_q.size(), arbitrate(beat));
    endtask

    task automatic test_idle_queries();
        send_beat(mrpla_pkg::REQ_QUERY, mrpla_pkg::KIND_POWER, 4'd0, 2'd0, 32'h0);
        send_beat(mrpla_pkg::REQ_QUERY, mrpla_pkg::KIND_FLOOR, 4'd9, 2'd3, 32'hFFFF_FFFF);
        send_beat(mrpla_pkg::REQ_DROP, KIND_WINDOW, 4'd3, 2'd2, 32'h0);
    endtask

    task automatic test_commit_minimum();
        send_beat(mrpla_pkg::REQ_COMMIT, mrpla_pkg::KIND_POWER, 4'd0, 2'd0, 32'hFFFF_FFFF);
        send_beat(mrpla_pkg::REQ_COMMIT, mrpla_pkg::KIND_POWER, 4'd1, 2'd0, 32'h0);
        send_beat(mrpla_pkg::REQ_COMMIT, KIND_WINDOW, 4'd15, 2'd3, 32'h5);
        send_beat(mrpla_pkg::REQ_COMMIT, KIND_DUTY, 4'd2, 2'd1, 32'h1234_5678);
    endtask

    task automatic test_preview();
        send_beat(mrpla_pkg::REQ_PREVIEW, mrpla_pkg::KIND_POWER, 4'd2, 2'd0, 32'h3);
        send_beat(mrpla_pkg::REQ_PREVIEW, KIND_WINDOW, 4'd3, 2'd2, 32'h8000_0000);
        send_beat(mrpla_pkg::REQ_PREVIEW, mrpla_pkg::KIND_FLOOR, 4'd4, 2'd0, 32'h1);
    endtask

    task automatic test_floor_bit();
        send_beat(mrpla_pkg::REQ_COMMIT, mrpla_pkg::KIND_FLOOR, 4'd0, 2'd2, 32'hFFFF_FFFE);
        send_beat(mrpla_pkg::REQ_QUERY, mrpla_pkg::KIND_FLOOR, 4'd0, 2'd0, 32'h0);
        send_beat(mrpla_pkg::REQ_COMMIT, mrpla_pkg::KIND_FLOOR, 4'd1, 2'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_drop_power();
        send_beat(mrpla_pkg::REQ_DROP, KIND_DUTY, 4'd1, 2'd0, 32'h0);
        send_beat(mrpla_pkg::REQ_QUERY, mrpla_pkg::KIND_POWER, 4'd0, 2'd0, 32'h0);
        send_beat(mrpla_pkg::REQ_COMMIT, mrpla_pkg::KIND_POWER, 4'd0, 2'd0, 32'h7);
    endtask

    task automatic test_remove_requester();
        send_beat(mrpla_pkg::REQ_REMOVE, KIND_WINDOW, 4'd15, 2'd3, 32'h0);
        send_beat(mrpla_pkg::REQ_REMOVE, mrpla_pkg::KIND_POWER, 4'd0, 2'd0, 32'h0);
        send_beat(mrpla_pkg::REQ_REMOVE, mrpla_pkg::KIND_FLOOR, 4'd1, 2'd0, 32'h0);
        send_beat(mrpla_pkg::REQ_QUERY, mrpla_pkg::KIND_POWER, 4'd1, 2'd0, 32'h0);
    endtask

    task automatic test_spare_opcodes();
        send_beat(REQ_SPARE_FIRST, KIND_DUTY, 4'd2, 2'd1, 32'hFFFF_FFFF);
        send_beat(REQ_SPARE_LAST, KIND_DUTY, 4'd5, 2'd1, 32'h0);
    endtask

    task automatic test_random_traffic();
        int              pool;
        int              w;
        int              sel;
        logic [2:0]      op;
        logic [31:0]     value;
        pool = 2;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 120 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                sel   = $urandom_range(0, 2);
                pool  = (sel == 0) ? 2 : (sel == 1) ? 4 : REQUESTERS;
            end
            w = $urandom_range(0, 99);
            if (w < 35)      op = mrpla_pkg::REQ_COMMIT;
            else if (w < 50) op = mrpla_pkg::REQ_PREVIEW;
            else if (w < 58) op = mrpla_pkg::REQ_REMOVE;
            else if (w < 66) op = mrpla_pkg::REQ_DROP;
            else if (w < 86) op = mrpla_pkg::REQ_QUERY;
            else             op = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
            sel = $urandom_range(0, 9);
            if (sel == 0)      value = 32'h0;
            else if (sel == 1) value = 32'hFFFF_FFFF;
            else if (sel < 6)  value = $urandom_range(0, 15);
            else               value = $urandom();
            send_beat(op, 2'($urandom_range(0, 3)), 4'($urandom_range(0, pool - 1)),
                      2'($urandom_range(0, CTRL_TYPES - 1)), value);
        end
    endtask

    initial begin
        int hold;
        i_rsp_stall = 1'b0;
        forever begin
            hold = pick_gap();
            repeat (hold) begin
                @(negedge i_clk);
                i_rsp_stall = 1'b1;
            end
            @(negedge i_clk);
            i_rsp_stall = 1'b0;
            do @(posedge i_clk); while (!(o_rsp_valid && !i_rsp_stall));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
            if (arb_result_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h/%b",
                         $time, o_rsp.result_value, o_rsp.result_valid);
                err_count++;
            end else begin
                head_result = arb_result_q.pop_front();
                if (o_rsp.result_value !== head_result.result_value) begin
                    $display("%0t: result_value expected %h actual %h",
                             $time, head_result.result_value, o_rsp.result_value);
                    err_count++;
                end
                if (o_rsp.result_valid !== head_result.result_valid) begin
                    $display("%0t: result_valid expected %b actual %b",
                             $time, head_result.result_valid, o_rsp.result_valid);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        err_count   = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        for (int k = 0; k < NKIND; k++) begin
            for (int r = 0; r < REQUESTERS; r++) begin
                rq_pres[k][r] = 1'b0;
                for (int t = 0; t < CTRL_TYPES; t++) req_pres[k][r][t] = 1'b0;
            end
            for (int t = 0; t < CTRL_TYPES; t++) arb_pres[k][t] = 1'b0;
        end
        for (int r = 0; r < REQUESTERS; r++) begin
            flr_bit[r]  = 1'b0;
            flr_pres[r] = 1'b0;
        end
        flr_arb_v  = 1'b0;
        flr_arb_ok = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_queries();
        test_commit_minimum();
        test_preview();
        test_floor_bit();
        test_drop_power();
        test_remove_requester();
        test_spare_opcodes();
        test_random_traffic();

        @(negedge i_clk);
        i_req_valid = 1'b0;
        while (arb_result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) $display("simulation ok");
        else                $display("simulation failed");
        $finish;
    end
endmodule
